### design/bsa_pkg.sv
`default_nettype none
package bsa_pkg;

  localparam int RES_COUNT_DEF  = 4;
  localparam int PROC_COUNT_DEF = 8;
  localparam int UNIT_WIDTH_DEF = 8;

  typedef enum logic [2:0] {
    OP_SET_TOTAL = 3'd0,
    OP_SET_CLAIM = 3'd1,
    OP_ALLOCATE  = 3'd2,
    OP_RELEASE   = 3'd3,
    OP_TERMINATE = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_DONE         = 3'd0,
    ST_BAD_IDS      = 3'd1,
    ST_OVER_CLAIM   = 3'd2,
    ST_WAIT_UNAVAIL = 3'd3,
    ST_WAIT_UNSAFE  = 3'd4,
    ST_OVER_RELEASE = 3'd5,
    ST_TERMINATED   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    C_NOP,
    C_CLAIM,
    C_ADD,
    C_SUB,
    C_TERM
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SUM,
    S_CHECK,
    S_FIN
  } state_t;

  typedef struct packed {
    cell_op_t   op;
    logic [2:0] pid;
    logic [1:0] rid;
    logic       chk_load;
    logic       chk_step;
  } bsa_cmd_t;

endpackage
`default_nettype wire

### design/bsa_in_if.sv
`default_nettype none
interface bsa_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [2:0] process_id;
  logic [1:0] resource_id;
  logic [7:0] amount;

  modport source (output valid, opcode, process_id, resource_id, amount, input ready);
  modport sink   (input valid, opcode, process_id, resource_id, amount, output ready);
endinterface
`default_nettype wire

### design/bsa_out_if.sv
`default_nettype none
interface bsa_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] available_now;

  modport source (output valid, status, available_now, input ready);
  modport sink   (input valid, status, available_now, output ready);
endinterface
`default_nettype wire

### design/bsa_cell.sv
`default_nettype none
module bsa_cell import bsa_pkg::*; #(
  parameter int IDX        = 0,
  parameter int RES_COUNT  = RES_COUNT_DEF,
  parameter int UNIT_WIDTH = UNIT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bsa_cmd_t                               cmd,
  input  logic [UNIT_WIDTH-1:0]                  amt,
  input  logic [RES_COUNT-1:0][UNIT_WIDTH-1:0]   work,
  input  logic                                   grant_in,
  input  logic                                   pend_in,
  input  logic [RES_COUNT-1:0][UNIT_WIDTH-1:0]   acc_in,
  output logic                                   grant_out,
  output logic                                   pend_out,
  output logic [RES_COUNT-1:0][UNIT_WIDTH-1:0]   acc_out,
  output logic [RES_COUNT-1:0][UNIT_WIDTH-1:0]   alloc_row,
  output logic [UNIT_WIDTH-1:0]                  claim_at,
  output logic                                   running
);
  localparam int RIW = (RES_COUNT > 1) ? $clog2(RES_COUNT) : 1;

  logic [RES_COUNT-1:0][UNIT_WIDTH-1:0] alloc_r, alloc_nxt;
  logic [RES_COUNT-1:0][UNIT_WIDTH-1:0] claim_r, claim_nxt;
  logic                                 run_r, run_nxt;
  logic                                 pend_r, pend_nxt;
  logic                                 fits, take, sel;
  logic [RIW-1:0]                       rid_i;

  assign sel   = (int'(cmd.pid) == IDX);
  assign rid_i = RIW'(cmd.rid);

  always_comb begin
    fits = 1'b1;
    for (int r = 0; r < RES_COUNT; r++) begin
      if (claim_r[r] > alloc_r[r] && (claim_r[r] - alloc_r[r]) > work[r]) fits = 1'b0;
    end
  end

  // first pending row that fits takes the grant; later rows see it and hold
  assign take      = cmd.chk_step && pend_r && fits && !grant_in;
  assign grant_out = grant_in | (pend_r & fits);
  assign pend_out  = pend_in | pend_r;
  assign acc_out   = take ? (acc_in | alloc_r) : acc_in;
  assign alloc_row = alloc_r;
  assign claim_at  = claim_r[rid_i];
  assign running   = run_r;

  always_comb begin
    alloc_nxt = alloc_r;
    claim_nxt = claim_r;
    run_nxt   = run_r;
    if (sel) begin
      case (cmd.op)
        C_CLAIM: claim_nxt[rid_i] = amt;
        C_ADD:   alloc_nxt[rid_i] = alloc_r[rid_i] + amt;
        C_SUB:   alloc_nxt[rid_i] = alloc_r[rid_i] - amt;
        C_TERM: begin
          alloc_nxt = '0;
          run_nxt   = 1'b0;
        end
        default: ;
      endcase
    end
    if (cmd.chk_load) pend_nxt = run_nxt;
    else if (take)    pend_nxt = 1'b0;
    else              pend_nxt = pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
      claim_r <= '0;
      run_r   <= 1'b1;
      pend_r  <= 1'b0;
    end else begin
      alloc_r <= alloc_nxt;
      claim_r <= claim_nxt;
      run_r   <= run_nxt;
      pend_r  <= pend_nxt;
    end
  end
endmodule
`default_nettype wire

### design/bankers_safe_allocator.sv
`default_nettype none
// Channel  | Dir | Payload                                     | Transfer
// in_ch    | in  | opcode, process_id, resource_id, amount     | valid & ready
// out_ch   | out | status, available_now                       | valid & ready
//
// One op at a time. Set claim, release, terminate and rejected ops go from execute straight
// to the final state; set total first sums the PROC_COUNT rows, one row summed per cycle.
// An accepted allocate runs safety passes, one grant of the cell chain per cycle; the
// undo of an unsafe trial happens in the last pass.
// Reset (synchronous, rst_n low) clears all counts and marks every process running.
// A waiting result does not block the next transfer in; the op then holds in its final
// state until the output register frees.
module bankers_safe_allocator import bsa_pkg::*; #(
  parameter int RES_COUNT  = RES_COUNT_DEF,
  parameter int PROC_COUNT = PROC_COUNT_DEF,
  parameter int UNIT_WIDTH = UNIT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bsa_in_if.sink    in_ch,
  bsa_out_if.source out_ch
);
  localparam int UW  = UNIT_WIDTH;
  localparam int NR  = RES_COUNT;
  localparam int NP  = PROC_COUNT;
  localparam int RIW = (NR > 1) ? $clog2(NR) : 1;
  localparam int PIW = (NP > 1) ? $clog2(NP) : 1;
  localparam int SW  = UW + PIW + 1;

  typedef logic [NR-1:0][UW-1:0] row_t;

  state_t             state_r, state_nxt;
  logic [2:0]         op_r, pid_r;
  logic [1:0]         rid_r;
  logic [UW-1:0]      amt_r;
  row_t               avail_r, avail_nxt;
  row_t               work_r, work_nxt;
  logic [SW-1:0]      used_r, used_nxt;
  logic [PIW-1:0]     cnt_r, cnt_nxt;
  status_t            res_r, res_nxt;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [7:0]         out_avail_r;
  bsa_cmd_t           cmd;

  logic [UW+7:0]      amt_ext;
  logic [UW+7:0]      avail_ext;
  logic               pok, rok, fin_go;
  logic [PIW-1:0]     pid_i;
  logic [RIW-1:0]     rid_i;
  logic [UW-1:0]      a_sel, c_sel, av_sel;
  logic [UW:0]        s_sum;

  row_t               row    [NP];
  logic [UW-1:0]      claim  [NP];
  logic               run    [NP];
  logic [NP:0]        grant_c, pend_c;
  row_t               acc_c  [NP+1];

  assign amt_ext = {{UW{1'b0}}, in_ch.amount};
  assign pok     = (int'(pid_r) < NP);
  assign rok     = (int'(rid_r) < NR);
  assign pid_i   = PIW'(pid_r);
  assign rid_i   = RIW'(rid_r);
  assign a_sel   = row[pid_i][rid_i];
  assign c_sel   = claim[pid_i];
  assign av_sel  = avail_r[rid_i];
  assign fin_go  = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // cell chain: grant, pending and allocation pass from row 0 upward
  assign grant_c[0] = 1'b0;
  assign pend_c[0]  = 1'b0;
  assign acc_c[0]   = '0;

  for (genvar p = 0; p < NP; p++) begin : g_cell
    bsa_cell #(.IDX(p), .RES_COUNT(NR), .UNIT_WIDTH(UW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .amt       (amt_r),
      .work      (work_r),
      .grant_in  (grant_c[p]),
      .pend_in   (pend_c[p]),
      .acc_in    (acc_c[p]),
      .grant_out (grant_c[p+1]),
      .pend_out  (pend_c[p+1]),
      .acc_out   (acc_c[p+1]),
      .alloc_row (row[p]),
      .claim_at  (claim[p]),
      .running   (run[p])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_FIN;
        if (op_r == OP_SET_TOTAL && rok) state_nxt = S_SUM;
        if (op_r == OP_ALLOCATE && rok && pok &&
            !(({1'b0, a_sel} + {1'b0, amt_r}) > {1'b0, c_sel}) &&
            !(amt_r > av_sel)) state_nxt = S_CHECK;
      end
      S_SUM:   if (int'(cnt_r) == NP - 1) state_nxt = S_FIN;
      S_CHECK: if (!pend_c[NP] || !grant_c[NP]) state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and cell commands
  always_comb begin
    avail_nxt    = avail_r;
    work_nxt     = work_r;
    used_nxt     = used_r;
    cnt_nxt      = cnt_r;
    res_nxt      = res_r;
    cmd.op       = C_NOP;
    cmd.pid      = pid_r;
    cmd.rid      = rid_r;
    cmd.chk_load = 1'b0;
    cmd.chk_step = 1'b0;
    s_sum        = {1'b0, av_sel} + {1'b0, amt_r};
    case (state_r)
      S_EXEC: begin
        res_nxt  = ST_DONE;
        used_nxt = '0;
        cnt_nxt  = '0;
        if (op_r == OP_TERMINATE) begin
          if (!pok) res_nxt = ST_BAD_IDS;
          else if (!run[pid_i]) res_nxt = ST_TERMINATED;
          else begin
            cmd.op = C_TERM;
            for (int r = 0; r < NR; r++) begin
              logic [UW:0] t;
              t = {1'b0, avail_r[r]} + {1'b0, row[pid_i][r]};
              avail_nxt[r] = t[UW] ? {UW{1'b1}} : t[UW-1:0];
            end
          end
        end else if (op_r > OP_TERMINATE || !rok) begin
          res_nxt = ST_BAD_IDS;
        end else if (op_r == OP_SET_TOTAL) begin
          res_nxt = ST_DONE;
        end else if (!pok) begin
          res_nxt = ST_BAD_IDS;
        end else begin
          case (op_r)
            OP_SET_CLAIM: cmd.op = C_CLAIM;
            OP_ALLOCATE: begin
              if (({1'b0, a_sel} + {1'b0, amt_r}) > {1'b0, c_sel}) res_nxt = ST_OVER_CLAIM;
              else if (amt_r > av_sel) res_nxt = ST_WAIT_UNAVAIL;
              else begin
                // trial apply, then load the check
                cmd.op           = C_ADD;
                cmd.chk_load     = 1'b1;
                avail_nxt[rid_i] = av_sel - amt_r;
                work_nxt         = avail_nxt;
              end
            end
            default: begin
              if (a_sel < amt_r) res_nxt = ST_OVER_RELEASE;
              else begin
                cmd.op           = C_SUB;
                avail_nxt[rid_i] = s_sum[UW] ? {UW{1'b1}} : s_sum[UW-1:0];
              end
            end
          endcase
        end
      end
      S_SUM: begin
        used_nxt = used_r + SW'(row[cnt_r][rid_i]);
        cnt_nxt  = cnt_r + PIW'(1);
        if (int'(cnt_r) == NP - 1) begin
          avail_nxt[rid_i] = ({{(SW-UW){1'b0}}, amt_r} > used_nxt) ?
                             amt_r - used_nxt[UW-1:0] : '0;
        end
      end
      S_CHECK: begin
        cmd.chk_step = 1'b1;
        if (pend_c[NP] && grant_c[NP]) begin
          for (int r = 0; r < NR; r++) begin
            logic [UW:0] w;
            w = {1'b0, work_r[r]} + {1'b0, acc_c[NP][r]};
            work_nxt[r] = w[UW] ? {UW{1'b1}} : w[UW-1:0];
          end
        end else if (pend_c[NP]) begin
          // no row fits: undo the trial
          cmd.op           = C_SUB;
          avail_nxt[rid_i] = av_sel + amt_r;
          res_nxt          = ST_WAIT_UNSAFE;
        end
      end
      default: ;
    endcase
  end

  assign avail_ext = {8'b0, av_sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      avail_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      avail_r <= avail_nxt;
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    used_r <= used_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= in_ch.opcode;
      pid_r <= in_ch.process_id;
      rid_r <= in_ch.resource_id;
      amt_r <= amt_ext[UW-1:0];
    end
    if (fin_go) begin
      out_status_r <= res_r;
      out_avail_r  <= (op_r <= OP_TERMINATE && rok) ? avail_ext[7:0] : 8'd0;
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.available_now = out_avail_r;

`ifndef ASSERT_OFF
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == S_EXEC)
    else $error("accepted op did not enter execute");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r)
    else $error("finished op did not reach output");
  a_check_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && !pend_c[NP]) |=> (state_r == S_FIN && res_r == ST_DONE))
    else $error("safe check did not finish done");
  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cmd.op == C_NOP))
    else $error("cell command issued while idle");
`endif
endmodule
`default_nettype wire
